// ===== rtl/fsp_pkg.sv =====
// Package of the Firmata stream parser: command codes, result kinds,
// the result record and the control record sent to the sysex unit.
// No dependencies.
package fsp_pkg;

  localparam int unsigned BufferDepthDefault = 64;
  localparam int unsigned MaxRun             = 63;

  localparam logic [7:0] CmdAnalog     = 8'hE0;
  localparam logic [7:0] CmdDigital    = 8'h90;
  localparam logic [7:0] CmdVersion    = 8'hF9;
  localparam logic [7:0] CmdRepAnalog  = 8'hC0;
  localparam logic [7:0] CmdRepDigital = 8'hD0;
  localparam logic [7:0] SyxStart      = 8'hF0;
  localparam logic [7:0] SyxEnd        = 8'hF7;
  localparam logic [7:0] SyxFirmware   = 8'h79;
  localparam logic [7:0] SyxString     = 8'h71;
  localparam logic [7:0] CmdNibbleMask = 8'hF0;
  localparam logic [7:0] DataLimit     = 8'd128;

  localparam logic [2:0] KindAnalog   = 3'd0;
  localparam logic [2:0] KindDigital  = 3'd1;
  localparam logic [2:0] KindVersion  = 3'd2;
  localparam logic [2:0] KindSysex    = 3'd3;
  localparam logic [2:0] KindString   = 3'd4;
  localparam logic [2:0] KindFirmware = 3'd5;

  localparam int unsigned EnAnalogBit  = 0;
  localparam int unsigned EnDigitalBit = 1;
  localparam int unsigned EnStringBit  = 2;
  localparam int unsigned EnSysexBit   = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [13:0] value;
    logic [7:0]  sysex_command;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [5:0]  position;
    logic        last;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic       start;   // sysex start byte seen outside sysex
    logic       store;   // payload byte inside sysex
    logic       finish;  // end byte inside sysex
    logic [7:0] data;
  } sx_ctrl_t;

endpackage

// ===== rtl/fsp_out_buf.sv =====
// Two-entry output buffer (output register plus skid register) for results.
// Depends on fsp_pkg.
module fsp_out_buf (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  fsp_pkg::res_t push_res_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output fsp_pkg::res_t pop_res_o
);
  import fsp_pkg::*;

  logic main_v_q, main_v_d, skid_v_q, skid_v_d;
  res_t main_q, main_d, skid_q, skid_d;
  logic pop;

  assign push_ready_o = !skid_v_q;
  assign pop_valid_o  = main_v_q;
  assign pop_res_o    = main_q;
  assign pop          = main_v_q && pop_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      main_v_d = 1'b0;
    end
    if (pop && skid_v_q) begin
      main_v_d = 1'b1;
      main_d   = skid_q;
      skid_v_d = 1'b0;
    end
    if (push_valid_i && !skid_v_q) begin
      if (!main_v_q || pop) begin
        main_v_d = 1'b1;
        main_d   = push_res_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = push_res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held while output register is empty");

  a_pop_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_v_q) |=> (main_v_q && !skid_v_q))
    else $error("skid entry not moved into output register");

endmodule

// ===== rtl/fsp_sysex_unit.sv =====
// Sysex buffer and readout sequencer: stores payload bytes in a synchronous
// memory and turns a finished message into a run of results.
// Depends on fsp_pkg.
module fsp_sysex_unit #(
  parameter int unsigned BufferDepth = fsp_pkg::BufferDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsp_pkg::sx_ctrl_t  ctrl_i,
  input  logic [3:0]         event_enable_i,
  output logic               busy_o,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output fsp_pkg::res_t      push_res_o
);
  import fsp_pkg::*;

  localparam int unsigned AW = $clog2(BufferDepth);
  localparam int unsigned CW = $clog2(BufferDepth + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CMD      = 10'b00_0000_0010,
    S_MAJ      = 10'b00_0000_0100,
    S_MIN      = 10'b00_0000_1000,
    S_TXT_LO   = 10'b00_0001_0000,
    S_TXT_HI   = 10'b00_0010_0000,
    S_TXT_EMIT = 10'b00_0100_0000,
    S_TERM     = 10'b00_1000_0000,
    S_RAW_RD   = 10'b01_0000_0000,
    S_RAW_EMIT = 10'b10_0000_0000
  } state_e;

  logic [7:0]    mem [BufferDepth];
  logic [7:0]    rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [5:0]    k_q, k_d;
  logic [CW-1:0] j_q, j_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] chars_q, chars_d;
  logic [7:0]    cmd_q, cmd_d, maj_q, maj_d, mnr_q, mnr_d, lo_q, lo_d;
  logic [2:0]    kind_q, kind_d;

  logic [7:0]    char_val;
  logic          last_char, run_cap, push_last;
  logic [CW-1:0] fw_len;

  assign char_val  = lo_q + {rd_data_q[0], 7'b0};
  assign last_char = (j_q == chars_q - 1'b1);
  assign run_cap   = (k_q == 6'(MaxRun - 1));
  assign fw_len    = (count_q > CW'(3)) ? (count_q - CW'(3)) : '0;
  assign wr_en     = (state_q == S_IDLE) && ctrl_i.store && (count_q < CW'(BufferDepth));
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_en = ctrl_i.finish && (count_q != '0);
      end
      S_CMD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      S_MAJ: begin
        rd_en   = 1'b1;
        rd_addr = AW'(2);
      end
      S_TXT_LO, S_RAW_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_q;
      end
      S_TXT_HI: begin
        rd_en   = 1'b1;
        rd_addr = addr_q + 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= ctrl_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    k_d       = k_q;
    j_d       = j_q;
    addr_d    = addr_q;
    chars_d   = chars_q;
    cmd_d     = cmd_q;
    maj_d     = maj_q;
    mnr_d     = mnr_q;
    lo_d      = lo_q;
    kind_d    = kind_q;
    push_valid_o = 1'b0;
    push_last    = 1'b0;
    push_res_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (ctrl_i.start) begin
          count_d   = '0;
          dropped_d = 1'b0;
        end else if (ctrl_i.store) begin
          if (count_q < CW'(BufferDepth)) begin
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
        end else if (ctrl_i.finish && (count_q != '0)) begin
          k_d     = '0;
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        cmd_d = rd_data_q;
        j_d   = '0;
        if (rd_data_q == SyxFirmware) begin
          kind_d  = KindFirmware;
          state_d = event_enable_i[EnSysexBit] ? S_MAJ : S_IDLE;
        end else if (rd_data_q == SyxString) begin
          kind_d  = KindString;
          maj_d   = '0;
          mnr_d   = '0;
          addr_d  = AW'(1);
          chars_d = (count_q - 1'b1) >> 1;
          if (!event_enable_i[EnStringBit]) begin
            state_d = S_IDLE;
          end else if (((count_q - 1'b1) >> 1) == '0) begin
            state_d = S_TERM;
          end else begin
            state_d = S_TXT_LO;
          end
        end else begin
          kind_d  = KindSysex;
          maj_d   = '0;
          mnr_d   = '0;
          addr_d  = AW'(1);
          state_d = (event_enable_i[EnSysexBit] && (count_q > CW'(1))) ? S_RAW_RD : S_IDLE;
        end
      end
      S_MAJ: begin
        maj_d   = (count_q > CW'(1)) ? rd_data_q : '0;
        state_d = S_MIN;
      end
      S_MIN: begin
        mnr_d   = (count_q > CW'(2)) ? rd_data_q : '0;
        addr_d  = AW'(3);
        chars_d = fw_len >> 1;
        state_d = ((fw_len >> 1) == '0) ? S_TERM : S_TXT_LO;
      end
      S_TXT_LO: begin
        state_d = S_TXT_HI;
      end
      S_TXT_HI: begin
        lo_d    = rd_data_q;
        state_d = S_TXT_EMIT;
      end
      S_TXT_EMIT: begin
        push_valid_o = 1'b1;
        push_last    = run_cap || (last_char && (char_val == '0));
        push_res_o.value = {6'b0, char_val};
        if (push_ready_i) begin
          k_d = k_q + 1'b1;
          if (push_last) begin
            state_d = S_IDLE;
          end else if (last_char) begin
            state_d = S_TERM;
          end else begin
            j_d     = j_q + 1'b1;
            addr_d  = addr_q + AW'(2);
            state_d = S_TXT_LO;
          end
        end
      end
      S_TERM: begin
        push_valid_o = 1'b1;
        push_last    = 1'b1;
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_RAW_RD: begin
        state_d = S_RAW_EMIT;
      end
      S_RAW_EMIT: begin
        push_valid_o = 1'b1;
        push_last    = run_cap || (CW'(addr_q) == count_q - 1'b1);
        push_res_o.value = {6'b0, rd_data_q};
        if (push_ready_i) begin
          k_d = k_q + 1'b1;
          if (push_last) begin
            state_d = S_IDLE;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = S_RAW_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    push_res_o.kind          = kind_q;
    push_res_o.channel       = '0;
    push_res_o.sysex_command = cmd_q;
    push_res_o.major         = maj_q;
    push_res_o.minor         = mnr_q;
    push_res_o.position      = k_q;
    push_res_o.last          = push_last;
    push_res_o.overflow      = dropped_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      k_q       <= '0;
      j_q       <= '0;
      addr_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      k_q       <= k_d;
      j_q       <= j_d;
      addr_q    <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    cmd_q   <= cmd_d;
    maj_q   <= maj_d;
    mnr_q   <= mnr_d;
    lo_q    <= lo_d;
    kind_q  <= kind_d;
  end

  a_push_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (state_q != S_IDLE))
    else $error("sysex result pushed outside a run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_ready_i && push_last) |=> (state_q == S_IDLE))
    else $error("run continued after its last result");

  a_position_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_ready_i && !push_last) |=> (k_q == $past(k_q) + 6'd1))
    else $error("run position did not advance by one");

  a_no_store_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE))
    else $error("buffer written during readout");

endmodule

// ===== rtl/firmata_stream_parser.sv =====
// Top level of the Firmata stream parser: byte parser, sysex unit and
// output buffer. Depends on fsp_pkg, fsp_sysex_unit and fsp_out_buf.
//
// Each input transaction carries one received byte. Command and data bytes are
// parsed in the cycle they are accepted; an analog, digital or version message
// yields its single result at the accept of its last data byte, and the next
// byte is taken in the following cycle if the skid stage is free. Sysex
// payload bytes are written into a BufferDepth-entry synchronous memory, one
// per transaction; bytes beyond the buffer are dropped and the overflow flag
// of the run is set. The sysex end byte starts a readout run that holds off
// input while it runs: the command byte is read and decoded, a firmware report
// reads its version bytes, then each raw sysex result takes a read and an emit
// state, each string or firmware character a low read, a high read and an emit
// state, and a zero terminator its own state. The single read port of the
// buffer memory sets these steps. A run holds at most 63 results, each tagged
// with its position and a last marker. Results leave through an output
// register with a skid stage, so a waiting result does not stop the next byte.
// The event_enable register (reset 15) selects analog, digital, string and
// other sysex results; version results always appear. It must be written with
// cfg_we_i only while the block is idle; the block does not enforce this.
module firmata_stream_parser #(
  parameter int unsigned BufferDepth = fsp_pkg::BufferDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [13:0] value_o,
  output logic [7:0]  sysex_command_o,
  output logic [7:0]  major_o,
  output logic [7:0]  minor_o,
  output logic [5:0]  position_o,
  output logic        last_o,
  output logic        overflow_o
);
  import fsp_pkg::*;

  // Parser state. bytes pending counts the data bytes still owed. The second
  // data byte is used directly in the cycle it arrives, so only the first one
  // is kept.
  logic [3:0] event_enable_q, event_enable_d;
  logic       in_sysex_q, in_sysex_d;
  logic [1:0] pend_q, pend_d;
  logic [7:0] pcmd_q, pcmd_d;
  logic [3:0] chan_q, chan_d;
  logic [6:0] lo_q, lo_d;

  logic     accept;
  logic     sx_busy, sx_push_valid;
  res_t     sx_res, top_res, buf_push_res, out_res;
  logic     top_valid, buf_push_ready;
  sx_ctrl_t sx_ctrl;
  logic [7:0] cmd;

  // Input is held off while a readout run owns the output path, and while
  // the skid stage is full so that a single result always has a place.
  assign in_ready_o = !sx_busy && buf_push_ready;
  assign accept     = in_valid_i && in_ready_o;

  assign sx_ctrl.start  = accept && !in_sysex_q && (rx_byte_i == SyxStart);
  assign sx_ctrl.store  = accept && in_sysex_q && (rx_byte_i != SyxEnd);
  assign sx_ctrl.finish = accept && in_sysex_q && (rx_byte_i == SyxEnd);
  assign sx_ctrl.data   = rx_byte_i;

  // Bytes below 0xF0 carry the command in the high nibble.
  assign cmd = (rx_byte_i < SyxStart) ? (rx_byte_i & CmdNibbleMask) : rx_byte_i;

  assign event_enable_d = cfg_we_i ? cfg_wdata_i : event_enable_q;

  always_comb begin
    in_sysex_d = in_sysex_q;
    pend_d     = pend_q;
    pcmd_d     = pcmd_q;
    chan_d     = chan_q;
    lo_d       = lo_q;
    top_valid  = 1'b0;
    top_res    = '0;
    top_res.last = 1'b1;

    if (accept) begin
      if (in_sysex_q) begin
        if (rx_byte_i == SyxEnd) begin
          in_sysex_d = 1'b0;
        end
      end else if ((pend_q != 2'd0) && (rx_byte_i < DataLimit)) begin
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd2) begin
          lo_d = rx_byte_i[6:0];
        end else begin
          // Second data byte completes the message.
          pcmd_d = '0;
          top_res.channel = chan_q;
          top_res.value   = {rx_byte_i[6:0], lo_q};
          if (pcmd_q == CmdAnalog) begin
            top_res.kind = KindAnalog;
            top_valid    = event_enable_q[EnAnalogBit];
          end else if (pcmd_q == CmdDigital) begin
            top_res.kind = KindDigital;
            top_valid    = event_enable_q[EnDigitalBit];
          end else if (pcmd_q == CmdVersion) begin
            top_res.kind    = KindVersion;
            top_res.channel = '0;
            top_res.value   = '0;
            top_res.major   = {1'b0, lo_q};
            top_res.minor   = {1'b0, rx_byte_i[6:0]};
            top_valid       = 1'b1;
          end
        end
      end else if (rx_byte_i >= DataLimit) begin
        if (rx_byte_i < SyxStart) begin
          chan_d = rx_byte_i[3:0];
        end
        if ((cmd == CmdAnalog) || (cmd == CmdDigital) || (cmd == CmdVersion)) begin
          pend_d = 2'd2;
          pcmd_d = cmd;
        end else if ((cmd == CmdRepAnalog) || (cmd == CmdRepDigital)) begin
          pend_d = 2'd1;
          pcmd_d = cmd;
        end else if (cmd == SyxStart) begin
          in_sysex_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_enable_q <= 4'hF;
      in_sysex_q     <= 1'b0;
      pend_q         <= '0;
      pcmd_q         <= '0;
      chan_q         <= '0;
      lo_q           <= '0;
    end else begin
      event_enable_q <= event_enable_d;
      in_sysex_q     <= in_sysex_d;
      pend_q         <= pend_d;
      pcmd_q         <= pcmd_d;
      chan_q         <= chan_d;
      lo_q           <= lo_d;
    end
  end

  fsp_sysex_unit #(
    .BufferDepth(BufferDepth)
  ) u_sysex (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (sx_ctrl),
    .event_enable_i(event_enable_q),
    .busy_o        (sx_busy),
    .push_valid_o  (sx_push_valid),
    .push_ready_i  (buf_push_ready),
    .push_res_o    (sx_res)
  );

  // The parser pushes only while no run is active, so the two sources never
  // collide.
  assign buf_push_res = sx_busy ? sx_res : top_res;

  fsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(sx_push_valid || top_valid),
    .push_ready_o(buf_push_ready),
    .push_res_i  (buf_push_res),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_res_o   (out_res)
  );

  assign kind_o          = out_res.kind;
  assign channel_o       = out_res.channel;
  assign value_o         = out_res.value;
  assign sysex_command_o = out_res.sysex_command;
  assign major_o         = out_res.major;
  assign minor_o         = out_res.minor;
  assign position_o      = out_res.position;
  assign last_o          = out_res.last;
  assign overflow_o      = out_res.overflow;

endmodule

// ===== tb/fsp_event_checker.sv =====
// Result checker for the Firmata stream parser: follows the parser state from
// accepted input bytes, predicts every result run and compares field by field.
// Depends on fsp_pkg.
module fsp_event_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  fsp_pkg::res_t event_i,
  output int unsigned   mismatch_cnt_o,
  output int unsigned   awaited_cnt_o
);
  import fsp_pkg::*;

  localparam int unsigned Depth = BufferDepthDefault;

  logic [3:0]  enable_q;
  logic        in_sysex;
  logic [1:0]  data_left;
  logic [7:0]  msg_cmd;
  logic [3:0]  msg_chan;
  logic [6:0]  lsb_data;
  logic [6:0]  msb_data;
  logic [7:0]  sysex_buf [Depth];
  logic [6:0]  sysex_len;
  logic        sysex_dropped;
  res_t        run_events [$];
  res_t        awaited_events [$];
  int unsigned mismatches;

  // Appends one result to the run being built; a run is cut off at MaxRun.
  task automatic add_event(input logic [2:0] kind, input logic [3:0] chan,
                           input logic [13:0] val, input logic [7:0] cmd,
                           input logic [7:0] maj, input logic [7:0] mnr,
                           input logic ovf);
    res_t r;
    if (run_events.size() >= MaxRun) return;
    r.kind          = kind;
    r.channel       = chan;
    r.value         = val;
    r.sysex_command = cmd;
    r.major         = maj;
    r.minor         = mnr;
    r.position      = 6'(run_events.size());
    r.last          = 1'b0;
    r.overflow      = ovf;
    run_events.push_back(r);
  endtask

  // Marks the final result of the run and moves the run to the awaited list.
  task automatic close_run();
    res_t r;
    foreach (run_events[i]) begin
      r      = run_events[i];
      r.last = (i == run_events.size() - 1);
      awaited_events.push_back(r);
    end
    run_events.delete();
  endtask

  // Joins 7-bit pairs into characters; a zero terminator follows unless the
  // last character already is zero.
  task automatic decode_chars(input int unsigned first, input int unsigned len,
                              input logic [2:0] kind, input logic [7:0] cmd,
                              input logic [7:0] maj, input logic [7:0] mnr);
    int unsigned n_chars;
    int unsigned lo;
    logic [7:0]  ch;
    n_chars = len / 2;
    ch      = '0;
    for (int unsigned j = 0; j < n_chars; j++) begin
      lo = first + 2 * j;
      if (lo + 1 >= Depth) break;
      ch = sysex_buf[lo] + {sysex_buf[lo + 1][0], 7'b0};
      add_event(kind, '0, 14'(ch), cmd, maj, mnr, sysex_dropped);
    end
    if (n_chars == 0 || ch != '0) add_event(kind, '0, '0, cmd, maj, mnr, sysex_dropped);
  endtask

  task automatic close_sysex();
    logic [7:0] cmd;
    if (sysex_len == 0) return;
    cmd = sysex_buf[0];
    if (cmd == SyxFirmware) begin
      if (enable_q[EnSysexBit])
        decode_chars(3, (sysex_len > 3) ? sysex_len - 3 : 0, KindFirmware, cmd,
                     (sysex_len > 1) ? sysex_buf[1] : 8'h00,
                     (sysex_len > 2) ? sysex_buf[2] : 8'h00);
    end else if (cmd == SyxString) begin
      if (enable_q[EnStringBit]) decode_chars(1, sysex_len - 1, KindString, cmd, '0, '0);
    end else if (enable_q[EnSysexBit]) begin
      for (int unsigned i = 1; i < sysex_len; i++)
        add_event(KindSysex, '0, 14'(sysex_buf[i]), cmd, '0, '0, sysex_dropped);
    end
    close_run();
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] cmd;
    if (in_sysex) begin
      if (b == SyxEnd) begin
        in_sysex = 1'b0;
        close_sysex();
      end else if (sysex_len < Depth) begin
        sysex_buf[sysex_len] = b;
        sysex_len++;
      end else begin
        sysex_dropped = 1'b1;
      end
    end else if (data_left != 0 && b < DataLimit) begin
      data_left--;
      if (data_left == 1) lsb_data = b[6:0];
      else msb_data = b[6:0];
      if (data_left == 0) begin
        if (msg_cmd == CmdAnalog) begin
          if (enable_q[EnAnalogBit])
            add_event(KindAnalog, msg_chan, {msb_data, lsb_data}, '0, '0, '0, 1'b0);
        end else if (msg_cmd == CmdDigital) begin
          if (enable_q[EnDigitalBit])
            add_event(KindDigital, msg_chan, {msb_data, lsb_data}, '0, '0, '0, 1'b0);
        end else if (msg_cmd == CmdVersion) begin
          add_event(KindVersion, '0, '0, '0, {1'b0, lsb_data}, {1'b0, msb_data}, 1'b0);
        end
        close_run();
        msg_cmd = '0;
      end
    end else if (b >= DataLimit) begin
      cmd = b;
      if (b < SyxStart) begin
        cmd      = b & CmdNibbleMask;
        msg_chan = b[3:0];
      end
      if (cmd == CmdAnalog || cmd == CmdDigital || cmd == CmdVersion) begin
        data_left = 2'd2;
        msg_cmd   = cmd;
      end else if (cmd == CmdRepAnalog || cmd == CmdRepDigital) begin
        data_left = 2'd1;
        msg_cmd   = cmd;
      end else if (cmd == SyxStart) begin
        in_sysex      = 1'b1;
        sysex_len     = '0;
        sysex_dropped = 1'b0;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_ev;
    if (!rst_ni) begin
      enable_q      = 4'hF;
      in_sysex      = 1'b0;
      data_left     = '0;
      msg_cmd       = '0;
      msg_chan      = '0;
      lsb_data      = '0;
      msb_data      = '0;
      sysex_len     = '0;
      sysex_dropped = 1'b0;
      mismatches    = 0;
      run_events.delete();
      awaited_events.delete();
      mismatch_cnt_o <= 0;
      awaited_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) enable_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) parse_rx_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual %p", $time, event_i);
        end else begin
          exp_ev = awaited_events.pop_front();
          check_field("kind", 16'(exp_ev.kind), 16'(event_i.kind));
          check_field("channel", 16'(exp_ev.channel), 16'(event_i.channel));
          check_field("value", 16'(exp_ev.value), 16'(event_i.value));
          check_field("sysex_command", 16'(exp_ev.sysex_command),
                      16'(event_i.sysex_command));
          check_field("major", 16'(exp_ev.major), 16'(event_i.major));
          check_field("minor", 16'(exp_ev.minor), 16'(event_i.minor));
          check_field("position", 16'(exp_ev.position), 16'(event_i.position));
          check_field("last", 16'(exp_ev.last), 16'(event_i.last));
          check_field("overflow", 16'(exp_ev.overflow), 16'(event_i.overflow));
        end
      end
      mismatch_cnt_o <= mismatches;
      awaited_cnt_o  <= awaited_events.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the Firmata stream parser testbench: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict.
// Depends on fsp_pkg, firmata_stream_parser and fsp_event_checker.
module testbench;
  import fsp_pkg::*;

  // Any accept on either channel resets the watchdog. The longest quiet
  // stretch of a correct run is the hold-off before a register write.
  localparam int unsigned IdleLimit   = 2000;
  // Covers a readout run that gives no result and may still be busy after
  // the last awaited result has come.
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned PhaseBytes  = 56;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned MaxGap      = 17;
  // High nibble that the parser does not know; it still moves the channel.
  localparam logic [7:0]  CmdUnknown  = 8'hA0;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  channel;
  logic [13:0] value;
  logic [7:0]  sysex_command;
  logic [7:0]  major;
  logic [7:0]  minor;
  logic [5:0]  position;
  logic        is_last;
  logic        overflow;
  res_t        dut_event;

  int unsigned mismatch_cnt;
  int unsigned awaited_cnt;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold  = 0;
  int unsigned rcv_gap     = 0;
  logic        rcv_steady  = 1'b0;
  logic        snd_steady  = 1'b0;
  logic [7:0]  directed_q [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  firmata_stream_parser i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .channel_o      (channel),
    .value_o        (value),
    .sysex_command_o(sysex_command),
    .major_o        (major),
    .minor_o        (minor),
    .position_o     (position),
    .last_o         (is_last),
    .overflow_o     (overflow)
  );

  // The field order matches the packed result record of the package.
  assign dut_event = {kind, channel, value, sysex_command, major, minor, position,
                      is_last, overflow};

  fsp_event_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .event_i       (dut_event),
    .mismatch_cnt_o(mismatch_cnt),
    .awaited_cnt_o (awaited_cnt)
  );

  // Result side. After each result transaction the receiver draws a random
  // stall, possibly none, and keeps ready low for that long. Now and then it
  // flips into a steady mode with no stalls at all, so that back-to-back
  // results and long readout runs also see a receiver that never waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (out_valid) begin
      if ($urandom_range(0, 29) == 0) rcv_steady = !rcv_steady;
      rcv_gap = rcv_steady ? 0 : $urandom_range(0, MaxGap);
      if (rcv_gap != 0) begin
        out_ready  <= 1'b0;
        ready_hold <= rcv_gap;
      end
    end
  end

  // Watchdog: a hung handshake or a result that never comes ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sends one byte as one input transaction. The gap before the byte is
  // drawn first; valid only drops when there really is a gap, so a byte that
  // follows directly keeps valid high without a second update in that step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = snd_steady ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Holds the sender until every awaited result has come, then lets the
  // block finish any readout that gives no result before going on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_cnt != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_enable(input logic [3:0] mask);
    wait_idle();
    cfg_wdata <= mask;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] rand_data7();
    return {1'b0, 7'($urandom_range(0, 127))};
  endfunction

  // Any byte that does not close a sysex message.
  function automatic logic [7:0] rand_payload();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SyxEnd);
    return b;
  endfunction

  // One message of the stream. Most are well formed with random content;
  // the rest are stray bytes, interrupted messages and empty sysex, which
  // push the parser into its odd corners.
  task automatic send_random_message();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    pick       = $urandom_range(0, 99);
    snd_steady = ($urandom_range(0, 4) == 0);
    if (pick < 34) begin
      send_byte(((pick < 18) ? CmdAnalog : CmdDigital) | 8'($urandom_range(0, 15)));
      send_byte(rand_data7());
      send_byte(rand_data7());
    end else if (pick < 40) begin
      send_byte(CmdVersion);
      send_byte(rand_data7());
      send_byte(rand_data7());
    end else if (pick < 48) begin
      send_byte(((pick % 2) ? CmdRepAnalog : CmdRepDigital) | 8'($urandom_range(0, 15)));
      send_byte(rand_data7());
    end else if (pick < 62) begin
      // Raw sysex. A long payload now and then fills the buffer, drops bytes
      // and reaches the cap on the number of results in one run.
      send_byte(SyxStart);
      do c = rand_payload(); while (c == SyxString || c == SyxFirmware);
      send_byte(c);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 8);
      repeat (len) send_byte(rand_payload());
      send_byte(SyxEnd);
    end else if (pick < 72) begin
      // String: each character goes out as a low and a high 7-bit byte. Zero
      // characters, an odd trailing byte and over-long strings all occur.
      send_byte(SyxStart);
      send_byte(SyxString);
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(29, 33) : $urandom_range(0, 6);
      for (int unsigned i = 0; i < len; i++) begin
        c = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        send_byte({1'b0, c[6:0]});
        send_byte({1'b0, 6'($urandom_range(0, 63)), c[7]});
      end
      if ($urandom_range(0, 3) == 0) send_byte(rand_data7());
      send_byte(SyxEnd);
    end else if (pick < 82) begin
      // Firmware report; short ones lack the name or even the version.
      send_byte(SyxStart);
      send_byte(SyxFirmware);
      len = $urandom_range(0, 12);
      repeat (len) send_byte(rand_data7());
      send_byte(SyxEnd);
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      // A two-byte message cut short by another command byte.
      send_byte(CmdAnalog | 8'($urandom_range(0, 15)));
      send_byte(rand_data7());
      send_byte(8'($urandom_range(128, 255)));
      if (pick % 2) send_byte(rand_data7());
    end else begin
      send_byte(SyxStart);
      send_byte(SyxEnd);
    end
  endtask

  initial begin
    int unsigned phase_start;
    logic [3:0]  mask;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes with the reset value of event_enable: a stray data byte,
    // analog extremes, a digital message whose channel an unknown command moves
    // before its last data byte, version, both report commands, an empty sysex,
    // an empty string and a firmware report without a name.
    directed_q = '{8'h42,
                   CmdAnalog, 8'h00, 8'h00,
                   CmdAnalog | 8'h0F, 8'h7F, 8'h7F,
                   CmdDigital | 8'h05, 8'h01, CmdUnknown | 8'h03, 8'h7F,
                   CmdVersion, 8'h02, 8'h05,
                   CmdRepAnalog | 8'h03, 8'h01,
                   CmdRepDigital | 8'h0F, 8'h00,
                   SyxStart, SyxEnd,
                   SyxStart, SyxString, SyxEnd,
                   SyxStart, SyxFirmware, 8'h02, SyxEnd};
    foreach (directed_q[i]) send_byte(directed_q[i]);

    // Random phases, each under its own enable mask: all off, all on, a
    // mixed mask and then random masks. Every register write waits for the
    // block to drain, which also gives the sender its full pauses.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       mask = 4'h0;
        1:       mask = 4'hF;
        2:       mask = 4'b0101;
        default: mask = 4'($urandom_range(0, 15));
      endcase
      write_enable(mask);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_message();
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
